// ----- rtl/rate_monotonic_task_scheduler_top_assert.svh -----
// Assertion macros for the rate monotonic scheduler top level.
// Needs clk and rst_n in the scope of the including module.
`ifndef RATE_MONOTONIC_TASK_SCHEDULER_TOP_ASSERT_SVH
`define RATE_MONOTONIC_TASK_SCHEDULER_TOP_ASSERT_SVH

// same-cycle implication
`define RMTS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RMTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rmts_pkg.sv -----
// Shared constants for the rate monotonic scheduler.
// No dependencies.
package rmts_pkg;

    localparam logic [1:0] CMD_REGISTER   = 2'd0;
    localparam logic [1:0] CMD_DEREGISTER = 2'd1;
    localparam logic [1:0] CMD_YIELD      = 2'd2;
    localparam logic [1:0] CMD_TICK       = 2'd3;

    localparam logic [1:0] MODE_SLEEP = 2'd0;
    localparam logic [1:0] MODE_RUN   = 2'd1;
    localparam logic [1:0] MODE_READY = 2'd2;

    localparam logic [19:0] BOUND_RESET = 20'd693000;
    localparam logic [19:0] PPM         = 20'd1000000;

    localparam int PROD_W  = 36;
    localparam int SHARE_W = 21;
    localparam int IN_W    = 56;
    localparam int OUT_W   = 40;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL    = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_ADMIT  = 3'd3;
    localparam logic [2:0] ST_SCAN   = 3'd4;
    localparam logic [2:0] ST_YWRITE = 3'd5;
    localparam logic [2:0] ST_DWRITE = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

endpackage

// ----- rtl/rate_monotonic_task_scheduler_top.sv -----
// Rate monotonic scheduler: one result per command, in order.
// Register runs a multiply and a 36-step divider; deregister and tick scan the
// table one entry per cycle for lookup, then for the dispatch search; yield
// also writes its entry back between the two.
// One command at a time; next accepted once the result is in the output reg.
// Reset: all entries invalid, utilization and clock zero, nothing running,
// bound 693000. No clearing pass.
module rate_monotonic_task_scheduler_top #(
    parameter int MAX_TASKS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [19:0]               cfg_data,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // cmd[1:0], task_pid[17:2], period_ms[33:18], slice_ms[49:34]
    input  logic [rmts_pkg::IN_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // accepted[0], running_valid[1], running_pid[17:2], total_utilization[37:18]
    output logic [rmts_pkg::OUT_W-1:0] m_tdata
);
    import rmts_pkg::*;

    localparam int IDXW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW   = $clog2(MAX_TASKS + 1);
    localparam int DYNW = 35;   // release, started, mode
    localparam int STW  = 16 + 16 + SHARE_W;
    localparam int DCW  = $clog2(PROD_W + 1);

    // memories
    logic [STW-1:0]  stat_mem [MAX_TASKS];
    logic [DYNW-1:0] dyn_mem  [MAX_TASKS];
    logic [STW-1:0]  stat_q;
    logic [DYNW-1:0] dyn_q;

    logic [MAX_TASKS-1:0] valid_reg, valid_next;
    logic [2:0]  state_reg, state_next;
    logic [19:0] bound_reg;
    logic [19:0] sum_reg, sum_next;
    logic [31:0] now_reg, now_next, old_reg, old_next;
    logic        cur_valid_reg, cur_valid_next;
    logic [IDXW-1:0] cur_slot_reg, cur_slot_next;
    logic [15:0] cur_pid_reg, cur_pid_next;

    logic [1:0]  cmd_reg, cmd_next;
    logic [15:0] pid_reg, pid_next, period_reg, period_next, slice_reg, slice_next;
    logic        acc_reg, acc_next;
    logic        disp_reg, disp_next;
    logic [IDXW-1:0] free_reg, free_next;

    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            pv_reg;
    logic [IDXW-1:0] pidx_reg;

    logic            hit_reg, hit_next;
    logic [IDXW-1:0] hit_idx_reg, hit_idx_next;
    logic [DYNW-1:0] hit_dyn_reg, hit_dyn_next;
    logic [15:0]     hit_period_reg, hit_period_next, hit_pid_reg, hit_pid_next;

    logic [PROD_W-1:0] q_reg, q_next;
    logic [16:0]       rem_reg, rem_next;
    logic [DCW-1:0]    dcnt_reg, dcnt_next;

    logic            out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] out_data_reg, out_data_next;

    logic            rd_en;
    logic            wr_st_en, wr_dy_en;
    logic [IDXW-1:0] wr_addr;
    logic [STW-1:0]  wr_st_data;
    logic [DYNW-1:0] wr_dy_data;

    logic            has_free;
    logic [IDXW-1:0] free_slot;
    logic [SHARE_W-1:0] share_sat;
    logic [21:0]     admit_total;
    logic [16:0]     rem_sh;
    logic [31:0]     y_rel;
    logic            y_started;
    logic [1:0]      y_mode;

    // stored fields of the entry being scanned
    logic [15:0]        q_pid, q_period;
    logic [SHARE_W-1:0] q_share;
    logic [31:0]        q_rel;
    logic               q_started;
    logic [1:0]         q_mode;

    assign {q_pid, q_period, q_share} = stat_q;
    assign {q_rel, q_started, q_mode} = dyn_q;

    always_comb
    begin
        has_free  = 1'b0;
        free_slot = '0;
        for (int i = MAX_TASKS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                has_free  = 1'b1;
                free_slot = IDXW'(i);
            end
        end
    end

    assign rd_en     = (state_reg == ST_SCAN) && (cnt_reg < CW'(MAX_TASKS));
    assign share_sat = (|q_reg[PROD_W-1:20]) ? SHARE_W'(21'h100000) : q_reg[SHARE_W-1:0];
    assign admit_total = 22'(sum_reg) + 22'(share_sat);
    assign rem_sh    = {rem_reg[15:0], q_reg[PROD_W-1]};

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            stat_q <= stat_mem[cnt_reg[IDXW-1:0]];
            dyn_q  <= dyn_mem[cnt_reg[IDXW-1:0]];
        end
        if (wr_st_en)
            stat_mem[wr_addr] <= wr_st_data;
        if (wr_dy_en)
            dyn_mem[wr_addr] <= wr_dy_data;
    end

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        sum_next        = sum_reg;
        now_next        = now_reg;
        old_next        = old_reg;
        cur_valid_next  = cur_valid_reg;
        cur_slot_next   = cur_slot_reg;
        cur_pid_next    = cur_pid_reg;
        cmd_next        = cmd_reg;
        pid_next        = pid_reg;
        period_next     = period_reg;
        slice_next      = slice_reg;
        acc_next        = acc_reg;
        disp_next       = disp_reg;
        free_next       = free_reg;
        cnt_next        = cnt_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_dyn_next    = hit_dyn_reg;
        hit_period_next = hit_period_reg;
        hit_pid_next    = hit_pid_reg;
        q_next          = q_reg;
        rem_next        = rem_reg;
        dcnt_next       = dcnt_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        wr_st_en        = 1'b0;
        wr_dy_en        = 1'b0;
        wr_addr         = pidx_reg;
        wr_st_data      = {pid_reg, period_reg, share_sat};
        wr_dy_data      = {q_rel, q_started, MODE_READY};
        y_rel           = hit_dyn_reg[DYNW-1:3] + 32'(hit_period_reg);
        y_started       = 1'b1;
        y_mode          = MODE_SLEEP;
        if (!hit_dyn_reg[2])
        begin
            y_rel  = now_reg + 32'(hit_period_reg);
            y_mode = MODE_READY;
        end

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next    = s_tdata[1:0];
                    pid_next    = s_tdata[17:2];
                    period_next = s_tdata[33:18];
                    slice_next  = s_tdata[49:34];
                    acc_next    = 1'b0;
                    disp_next   = 1'b0;
                    hit_next    = 1'b0;
                    cnt_next    = '0;
                    free_next   = free_slot;
                    case (s_tdata[1:0])
                        CMD_REGISTER:
                            state_next = (has_free && (s_tdata[33:18] != 16'd0))
                                         ? ST_MUL : ST_DONE;
                        CMD_TICK:
                        begin
                            old_next   = now_reg;
                            now_next   = now_reg + 32'd1;
                            state_next = ST_SCAN;
                        end
                        default:
                            state_next = ST_SCAN;
                    endcase
                end
            end
            ST_MUL:
            begin
                q_next     = PROD_W'(slice_reg) * PROD_W'(PPM);
                rem_next   = '0;
                dcnt_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // one quotient bit per cycle, restoring
                if (rem_sh >= {1'b0, period_reg})
                begin
                    rem_next = rem_sh - {1'b0, period_reg};
                    q_next   = {q_reg[PROD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    q_next   = {q_reg[PROD_W-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg + DCW'(1);
                if (dcnt_reg == DCW'(PROD_W - 1))
                    state_next = ST_ADMIT;
            end
            ST_ADMIT:
            begin
                if (admit_total < 22'(bound_reg))
                begin
                    wr_st_en   = 1'b1;
                    wr_dy_en   = 1'b1;
                    wr_addr    = free_reg;
                    wr_dy_data = {32'd0, 1'b0, MODE_SLEEP};
                    valid_next[free_reg] = 1'b1;
                    sum_next   = admit_total[19:0];
                    acc_next   = 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                if (rd_en)
                    cnt_next = cnt_reg + CW'(1);
                if (pv_reg && valid_reg[pidx_reg])
                begin
                    if (disp_reg)
                    begin
                        if ((q_mode == MODE_READY || q_mode == MODE_RUN) &&
                            (!hit_reg || q_period < hit_period_reg))
                        begin
                            hit_next        = 1'b1;
                            hit_idx_next    = pidx_reg;
                            hit_dyn_next    = dyn_q;
                            hit_period_next = q_period;
                            hit_pid_next    = q_pid;
                        end
                    end
                    else
                    begin
                        case (cmd_reg)
                            CMD_DEREGISTER:
                            begin
                                if (q_pid == pid_reg)
                                begin
                                    sum_next = (21'(q_share) >= 21'(sum_next)) ? 20'd0
                                               : sum_next - q_share[19:0];
                                    valid_next[pidx_reg] = 1'b0;
                                    acc_next = 1'b1;
                                end
                            end
                            CMD_YIELD:
                            begin
                                if (q_pid == pid_reg && !hit_reg)
                                begin
                                    hit_next        = 1'b1;
                                    hit_idx_next    = pidx_reg;
                                    hit_dyn_next    = dyn_q;
                                    hit_period_next = q_period;
                                end
                            end
                            CMD_TICK:
                            begin
                                if (q_started && (q_rel == now_reg || q_rel == old_reg))
                                begin
                                    wr_dy_en = 1'b1;
                                    hit_next = 1'b1;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                if (!rd_en && !pv_reg)
                begin
                    cnt_next = '0;
                    if (disp_reg)
                        state_next = hit_reg ? ST_DWRITE : ST_DONE;
                    else
                    begin
                        state_next = ST_DONE;
                        hit_next   = 1'b0;
                        disp_next  = 1'b0;
                        case (cmd_reg)
                            CMD_DEREGISTER:
                            begin
                                if (acc_reg)
                                begin
                                    cur_valid_next = 1'b0;
                                    disp_next      = 1'b1;
                                    state_next     = ST_SCAN;
                                end
                            end
                            CMD_YIELD:
                            begin
                                if (hit_reg)
                                begin
                                    hit_next   = 1'b1;
                                    acc_next   = 1'b1;
                                    state_next = ST_YWRITE;
                                end
                            end
                            CMD_TICK:
                            begin
                                if (hit_reg)
                                begin
                                    disp_next  = 1'b1;
                                    state_next = ST_SCAN;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            ST_YWRITE:
            begin
                wr_dy_en   = 1'b1;
                wr_addr    = hit_idx_reg;
                wr_dy_data = {y_rel, y_started, y_mode};
                hit_next   = 1'b0;
                if (y_rel < now_reg)
                    state_next = ST_DONE;
                else
                begin
                    disp_next  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_DWRITE:
            begin
                wr_dy_en       = 1'b1;
                wr_addr        = hit_idx_reg;
                wr_dy_data     = {hit_dyn_reg[DYNW-1:2], MODE_RUN};
                cur_valid_next = 1'b1;
                cur_slot_next  = hit_idx_reg;
                cur_pid_next   = hit_pid_reg;
                state_next     = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {2'b00, sum_reg,
                                      cur_valid_reg ? cur_pid_reg : 16'd0,
                                      cur_valid_reg, acc_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            bound_reg     <= BOUND_RESET;
            sum_reg       <= '0;
            now_reg       <= '0;
            old_reg       <= '0;
            cur_valid_reg <= 1'b0;
            cur_slot_reg  <= '0;
            cnt_reg       <= '0;
            pv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            disp_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            acc_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            if (cfg_we)
                bound_reg <= cfg_data;
            sum_reg       <= sum_next;
            now_reg       <= now_next;
            old_reg       <= old_next;
            cur_valid_reg <= cur_valid_next;
            cur_slot_reg  <= cur_slot_next;
            cnt_reg       <= cnt_next;
            pv_reg        <= rd_en;
            out_valid_reg <= out_valid_next;
            disp_reg      <= disp_next;
            hit_reg       <= hit_next;
            acc_reg       <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg       <= cnt_reg[IDXW-1:0];
        cur_pid_reg    <= cur_pid_next;
        cmd_reg        <= cmd_next;
        pid_reg        <= pid_next;
        period_reg     <= period_next;
        slice_reg      <= slice_next;
        free_reg       <= free_next;
        hit_idx_reg    <= hit_idx_next;
        hit_dyn_reg    <= hit_dyn_next;
        hit_period_reg <= hit_period_next;
        hit_pid_reg    <= hit_pid_next;
        q_reg          <= q_next;
        rem_reg        <= rem_next;
        dcnt_reg       <= dcnt_next;
        out_data_reg   <= out_data_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`include "rate_monotonic_task_scheduler_top_assert.svh"

    // a deregister scan may clear the running entry's slot before cur_valid is cleared
    `RMTS_ASSERT_NOW(a_cur_valid, (state_reg == ST_IDLE) && cur_valid_reg, valid_reg[cur_slot_reg], "running slot invalid")
    `RMTS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, state_reg != ST_IDLE, "accept did not start work")
    `RMTS_ASSERT_NOW(a_scan_pipe, pv_reg, state_reg == ST_SCAN, "read data outside a scan")
    `RMTS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, $stable(m_tdata) && m_tvalid, "stalled result changed")

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for rate_monotonic_task_scheduler_top.
// Needs rmts_pkg and the top level; predicts every result with its own table model.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rmts_pkg::*;

    localparam int NTASK = 16;
    localparam int STALL_LIMIT = 5000;

    // lowest field last, matching m_tdata from bit 0 up
    typedef struct packed {
        logic [19:0] total_util;
        logic [15:0] running_pid;
        logic        running_valid;
        logic        accepted;
    } sched_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [19:0]         cfg_data = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;

    rate_monotonic_task_scheduler_top #(.MAX_TASKS(NTASK)) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 clk = ~clk;

    // scheduler shadow state
    bit          slot_used [NTASK];
    logic [15:0] slot_pid [NTASK];
    logic [15:0] slot_period [NTASK];
    logic [15:0] slot_slice [NTASK];
    logic [1:0]  slot_mode [NTASK];
    logic [31:0] slot_release [NTASK];
    bit          slot_started [NTASK];
    logic [19:0] util_sum = '0;
    logic [31:0] clock_ms = '0;
    bit          dispatched = 1'b0;
    int          cur_slot = 0;
    logic [19:0] util_bound = BOUND_RESET;

    sched_result_t pending_results[$];
    int  errors = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  hold_req = 0;
    int  hold_left = 0;
    int  quiet_cycles = 0;

    function automatic longint unsigned share_ppm(logic [15:0] sl, logic [15:0] per);
        longint unsigned p;
        if (per == 0)
            return 0;
        p = longint'(sl) * 1000000;
        return p / per;
    endfunction

    function automatic void pick_shortest_period();
        int  best;
        bit  found;
        best = 0;
        found = 0;
        for (int i = 0; i < NTASK; i++) begin
            if (slot_used[i] && (slot_mode[i] == MODE_READY || slot_mode[i] == MODE_RUN))
                if (!found || slot_period[i] < slot_period[best]) begin
                    best = i;
                    found = 1;
                end
        end
        if (found) begin
            slot_mode[best] = MODE_RUN;
            cur_slot = best;
            dispatched = 1;
        end
    endfunction

    function automatic sched_result_t apply_command(logic [1:0] cmd, logic [15:0] pid,
                                                    logic [15:0] per, logic [15:0] sl);
        sched_result_t    r;
        bit               acc;
        int               free_slot;
        longint unsigned  sum;
        longint unsigned  sh;
        logic [31:0]      prev;
        bit               fired;
        acc = 0;
        case (cmd)
            CMD_REGISTER: begin
                free_slot = -1;
                for (int i = NTASK - 1; i >= 0; i--)
                    if (!slot_used[i])
                        free_slot = i;
                if (per != 0 && free_slot >= 0) begin
                    sum = longint'(util_sum) + share_ppm(sl, per);
                    if (sum < util_bound) begin
                        slot_used[free_slot] = 1;
                        slot_pid[free_slot] = pid;
                        slot_period[free_slot] = per;
                        slot_slice[free_slot] = sl;
                        slot_mode[free_slot] = MODE_SLEEP;
                        slot_release[free_slot] = '0;
                        slot_started[free_slot] = 0;
                        util_sum = sum[19:0];
                        acc = 1;
                    end
                end
            end
            CMD_DEREGISTER: begin
                for (int i = 0; i < NTASK; i++)
                    if (slot_used[i] && slot_pid[i] == pid) begin
                        sh = share_ppm(slot_slice[i], slot_period[i]);
                        util_sum = (sh >= util_sum) ? 20'd0 : util_sum - sh[19:0];
                        slot_used[i] = 0;
                        acc = 1;
                    end
                if (acc) begin
                    dispatched = 0;
                    cur_slot = 0;
                    pick_shortest_period();
                end
            end
            CMD_YIELD: begin
                free_slot = -1;
                for (int i = NTASK - 1; i >= 0; i--)
                    if (slot_used[i] && slot_pid[i] == pid)
                        free_slot = i;
                if (free_slot >= 0) begin
                    acc = 1;
                    if (!slot_started[free_slot]) begin
                        slot_release[free_slot] = clock_ms + slot_period[free_slot];
                        slot_mode[free_slot] = MODE_READY;
                        slot_started[free_slot] = 1;
                    end else begin
                        slot_release[free_slot] = slot_release[free_slot]
                                                  + slot_period[free_slot];
                        slot_mode[free_slot] = MODE_SLEEP;
                    end
                    // late yield: release already passed, no dispatch
                    if (!(slot_release[free_slot] < clock_ms))
                        pick_shortest_period();
                end
            end
            default: begin
                prev = clock_ms;
                clock_ms = prev + 1;
                fired = 0;
                for (int i = 0; i < NTASK; i++)
                    if (slot_used[i] && slot_started[i] &&
                        (slot_release[i] == clock_ms || slot_release[i] == prev)) begin
                        slot_mode[i] = MODE_READY;
                        fired = 1;
                    end
                if (fired)
                    pick_shortest_period();
            end
        endcase
        r.accepted = acc;
        if (dispatched && slot_used[cur_slot]) begin
            r.running_valid = 1'b1;
            r.running_pid = slot_pid[cur_slot];
        end else begin
            r.running_valid = 1'b0;
            r.running_pid = '0;
        end
        r.total_util = util_sum;
        return r;
    endfunction

    task automatic send_cmd(logic [1:0] cmd, logic [15:0] pid, logic [15:0] per,
                            logic [15:0] sl);
        int gap;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, sl, per, pid, cmd};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(apply_command(cmd, pid, per, sl));
    endtask

    // let the block drain and sit idle before touching the bound
    task automatic drain_and_set_bound(logic [19:0] value);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        util_bound = value;
    endtask

    function automatic logic [15:0] pick_pid();
        if ($urandom_range(0, 9) == 0)
            return 16'($urandom);
        return 16'($urandom_range(1, 6));
    endfunction

    always @(posedge clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // result checker
    always @(posedge clk) begin
        sched_result_t got;
        sched_result_t exp_r;
        if (rst_n && m_tvalid && m_tready) begin
            got = m_tdata[37:0];
            if (pending_results.size() == 0) begin
                $display("%0t: result with none pending: got %h", $realtime, got);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (got.accepted !== exp_r.accepted) begin
                    $display("%0t: accepted exp %0d got %0d", $realtime,
                             exp_r.accepted, got.accepted);
                    errors++;
                end
                if (got.running_valid !== exp_r.running_valid) begin
                    $display("%0t: running_valid exp %0d got %0d", $realtime,
                             exp_r.running_valid, got.running_valid);
                    errors++;
                end
                if (got.running_pid !== exp_r.running_pid) begin
                    $display("%0t: running_pid exp %0d got %0d", $realtime,
                             exp_r.running_pid, got.running_pid);
                    errors++;
                end
                if (got.total_util !== exp_r.total_util) begin
                    $display("%0t: total_utilization exp %0d got %0d", $realtime,
                             exp_r.total_util, got.total_util);
                    errors++;
                end
            end
        end
    end

    // watchdog on transfers
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("rate_monotonic_task_scheduler_top regression: fail");
            $finish;
        end
    end

    task automatic test_directed();
        send_cmd(CMD_REGISTER, 16'd100, 16'd0, 16'd5);          // zero period
        send_cmd(CMD_REGISTER, 16'hFFFF, 16'hFFFF, 16'hFFFF);   // over the bound
        send_cmd(CMD_REGISTER, 16'd0, 16'd10, 16'd1);
        send_cmd(CMD_REGISTER, 16'd5, 16'd10, 16'd1);           // period tie
        send_cmd(CMD_REGISTER, 16'd5, 16'd20, 16'd2);           // duplicate pid
        send_cmd(CMD_DEREGISTER, 16'd777, 16'd0, 16'd0);
        send_cmd(CMD_YIELD, 16'd777, 16'd0, 16'd0);
        send_cmd(CMD_YIELD, 16'd0, 16'd0, 16'd0);
        send_cmd(CMD_YIELD, 16'd5, 16'd0, 16'd0);
        send_cmd(CMD_REGISTER, 16'd9, 16'd3, 16'd1);
        send_cmd(CMD_YIELD, 16'd9, 16'd0, 16'd0);
        repeat (11)
            send_cmd(CMD_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_cmd(CMD_YIELD, 16'd0, 16'd0, 16'd0);               // later yield
        send_cmd(CMD_YIELD, 16'd9, 16'd0, 16'd0);               // late yield
        send_cmd(CMD_DEREGISTER, 16'd5, 16'd0, 16'd0);          // all copies
        // fill the table with zero-share tasks
        drain_and_set_bound(20'd1000000);
        for (int i = 0; i < NTASK + 1; i++)
            send_cmd(CMD_REGISTER, 16'(1 + i % 6), 16'(40 - i), 16'd0);
    endtask

    task automatic test_random(int count);
        logic [1:0]  cmd;
        logic [15:0] per;
        logic [15:0] sl;
        int          roll;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 20) begin
                cmd = CMD_REGISTER;
                if ($urandom_range(0, 9) == 0) begin
                    per = 16'($urandom);
                    sl = 16'($urandom);
                end else begin
                    per = 16'($urandom_range(0, 30));
                    sl = 16'($urandom_range(0, per / 4 + 1));
                end
            end else begin
                cmd = (roll < 32) ? CMD_DEREGISTER : (roll < 58) ? CMD_YIELD : CMD_TICK;
                per = 16'($urandom);
                sl = 16'($urandom);
            end
            send_cmd(cmd, pick_pid(), per, sl);
        end
    endtask

    task automatic test_backpressure();
        hold_req = 400;
        test_random(30);
    endtask

    initial begin
        for (int i = 0; i < NTASK; i++)
            slot_used[i] = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        drain_and_set_bound(20'd0);
        test_random(40);
        drain_and_set_bound(20'd999999);
        send_idle_pct = 7;
        recv_idle_pct = 73;
        test_random(380);
        test_backpressure();
        drain_and_set_bound(20'($urandom_range(0, 1000000)));
        send_idle_pct = 73;
        recv_idle_pct = 7;
        test_random(360);
        drain_and_set_bound(BOUND_RESET);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(380);

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("rate_monotonic_task_scheduler_top regression: pass");
        else
            $display("rate_monotonic_task_scheduler_top regression: fail");
        $finish;
    end
endmodule

`default_nettype wire

// ----- rate_monotonic_task_scheduler_top.f -----
+incdir+rtl
rtl/rmts_pkg.sv
rtl/rate_monotonic_task_scheduler_top.sv
tb/tb.sv
